// ===== hw/rtl/v3au_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// v3au_pkg
// Shared widths, opcodes, item types and the saturation helper of the
// three-component vector unit.
// ---------------------------------------------------------------------------
package v3au_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SQ_W      = PROD_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int QUO_W     = DATA_W + 1;

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_SCALE = 4'd2;
  localparam logic [OP_W-1:0] OP_NEG   = 4'd3;
  localparam logic [OP_W-1:0] OP_DOT   = 4'd4;
  localparam logic [OP_W-1:0] OP_CROSS = 4'd5;
  localparam logic [OP_W-1:0] OP_NORM  = 4'd6;
  localparam logic [OP_W-1:0] OP_LEN   = 4'd7;
  localparam logic [OP_W-1:0] OP_SQLEN = 4'd8;
  localparam logic [OP_W-1:0] OP_EQUAL = 4'd9;

  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  // partial result of an item plus what normalize still needs
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] vx;
    logic [DATA_W-1:0] vy;
    logic [DATA_W-1:0] vz;
    logic [DATA_W-1:0] sc;
    logic              eq;
    logic              ovf;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] my;
    logic [DATA_W-1:0] mz;
    logic              nx;
    logic              ny;
    logic              nz;
  } side_t;

  function automatic sat_t sat_wide(input logic [SUM_W-1:0] v);
    sat_t                  r;
    logic [SUM_W-DATA_W:0] hi;
    hi = v[SUM_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      r.ovf = 1'b0;
      r.val = v[DATA_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[SUM_W-1] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/vec3_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vec3_arithmetic_unit_core
// Three-component vector unit in signed Q16.16: add, sub, scale, negate,
// dot, cross, normalize, length, squared length and equality.
//
//   channel | ports                                  | dir
//   --------+----------------------------------------+-----
//   input   | in_valid, in_stall, in_opcode, a, b, sf | in
//   result  | out_valid, out_stall, out_res_*, flags  | out
//
// one item enters per cycle while the result is not stalled; every item
// passes 3 front stages, 32 square-root stages (one root bit each), 33 divider
// stages (one quotient bit each) and the output register
// reset clears only the valid bits of the pipeline
// a stalled result freezes the whole pipeline, in_stall follows it
// ---------------------------------------------------------------------------
module vec3_arithmetic_unit_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [v3au_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_a_x,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_a_y,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_a_z,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_b_x,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_b_y,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_b_z,
  input  logic signed [v3au_pkg::DATA_W-1:0] in_scale_factor,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [v3au_pkg::DATA_W-1:0] out_res_x,
  output logic signed [v3au_pkg::DATA_W-1:0] out_res_y,
  output logic signed [v3au_pkg::DATA_W-1:0] out_res_z,
  output logic signed [v3au_pkg::DATA_W-1:0] out_scalar_out,
  output logic                               out_is_equal,
  output logic                               out_overflow,
  output logic                               out_zero_length
);
  import v3au_pkg::*;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] len;
  } post_t;

  logic              en;
  logic              fr_vld, sq_vld;
  side_t             fr_side, sq_side;
  logic [SQ_W-1:0]   fr_sq;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quo [3];
  logic              big [3];

  logic              pv_r [QUO_W];
  post_t             pd_r [QUO_W];

  logic                     out_valid_r;
  logic [DATA_W-1:0]        res_nxt [3];
  logic [DATA_W-1:0]        res_r [3];
  logic [DATA_W-1:0]        sc_nxt, sc_r;
  logic                     eq_nxt, eq_r, ovf_nxt, ovf_r, zl_nxt, zl_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = out_valid_r && out_stall;

  v3au_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .op       (in_opcode),
    .ax       (in_a_x),
    .ay       (in_a_y),
    .az       (in_a_z),
    .bx       (in_b_x),
    .by       (in_b_y),
    .bz       (in_b_z),
    .sf       (in_scale_factor),
    .out_vld  (fr_vld),
    .out_side (fr_side),
    .out_sq   (fr_sq)
  );

  v3au_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_rad   (fr_sq),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (root)
  );

  v3au_div u_div_x (
    .clk (clk), .en (en),
    .dvd ({sq_side.mx, {FRAC_BITS{1'b0}}}), .dvs (root),
    .quo (quo[0]), .big (big[0])
  );

  v3au_div u_div_y (
    .clk (clk), .en (en),
    .dvd ({sq_side.my, {FRAC_BITS{1'b0}}}), .dvs (root),
    .quo (quo[1]), .big (big[1])
  );

  v3au_div u_div_z (
    .clk (clk), .en (en),
    .dvd ({sq_side.mz, {FRAC_BITS{1'b0}}}), .dvs (root),
    .quo (quo[2]), .big (big[2])
  );

  // item data rides beside the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) pv_r[i] <= 1'b0;
    end else if (en) begin
      pv_r[0] <= sq_vld;
      for (int i = 1; i < QUO_W; i++) pv_r[i] <= pv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= '{side: sq_side, len: root};
      for (int i = 1; i < QUO_W; i++) pd_r[i] <= pd_r[i-1];
    end
  end

  always_comb begin
    post_t p;
    logic  neg [3];
    logic  over;
    p      = pd_r[QUO_W-1];
    over   = 1'b0;
    neg[0] = p.side.nx;
    neg[1] = p.side.ny;
    neg[2] = p.side.nz;
    res_nxt[0] = p.side.vx;
    res_nxt[1] = p.side.vy;
    res_nxt[2] = p.side.vz;
    sc_nxt     = p.side.sc;
    eq_nxt     = p.side.eq;
    ovf_nxt    = p.side.ovf;
    zl_nxt     = 1'b0;
    case (p.side.op)
      OP_NORM: begin
        if (p.len == '0) begin
          zl_nxt = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            // magnitude past the signed range on its side saturates
            if (neg[i]) over = big[i] | quo[i][QUO_W-1] |
                               (quo[i][DATA_W-1] & (|quo[i][DATA_W-2:0]));
            else        over = big[i] | quo[i][QUO_W-1] | quo[i][DATA_W-1];
            if (over) res_nxt[i] = neg[i] ? VAL_MIN : VAL_MAX;
            else      res_nxt[i] = neg[i] ? DATA_W'(-quo[i][DATA_W-1:0])
                                          : quo[i][DATA_W-1:0];
            ovf_nxt = ovf_nxt | over;
          end
        end
      end
      OP_LEN: begin
        if (p.len[ROOT_W-1]) begin
          sc_nxt  = VAL_MAX;
          ovf_nxt = 1'b1;
        end else begin
          sc_nxt  = DATA_W'(p.len);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) res_r[i] <= res_nxt[i];
      sc_r  <= sc_nxt;
      eq_r  <= eq_nxt;
      ovf_r <= ovf_nxt;
      zl_r  <= zl_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = res_r[0];
  assign out_res_y       = res_r[1];
  assign out_res_z       = res_r[2];
  assign out_scalar_out  = sc_r;
  assign out_is_equal    = eq_r;
  assign out_overflow    = ovf_r;
  assign out_zero_length = zl_r;

endmodule

// ===== hw/rtl/v3au_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// v3au_front
// Input register, product stage and sum/shift/saturate stage.
// ---------------------------------------------------------------------------
module v3au_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [v3au_pkg::OP_W-1:0]         op,
  input  logic signed [v3au_pkg::DATA_W-1:0] ax,
  input  logic signed [v3au_pkg::DATA_W-1:0] ay,
  input  logic signed [v3au_pkg::DATA_W-1:0] az,
  input  logic signed [v3au_pkg::DATA_W-1:0] bx,
  input  logic signed [v3au_pkg::DATA_W-1:0] by,
  input  logic signed [v3au_pkg::DATA_W-1:0] bz,
  input  logic signed [v3au_pkg::DATA_W-1:0] sf,
  output logic                              out_vld,
  output v3au_pkg::side_t                   out_side,
  output logic [v3au_pkg::SQ_W-1:0]         out_sq
);
  import v3au_pkg::*;

  logic                     vld1_r, vld2_r, vld3_r;
  logic [OP_W-1:0]          op1_r, op2_r;
  logic signed [DATA_W-1:0] a1_r [3];
  logic signed [DATA_W-1:0] b1_r [3];
  logic signed [DATA_W-1:0] s1_r;

  logic signed [DATA_W-1:0] lhs [6];
  logic signed [DATA_W-1:0] rhs [6];
  logic signed [PROD_W-1:0] p2_r [6];
  sat_t                     vec_nxt [3];
  sat_t                     vec2_r [3];
  logic                     eq_nxt, eq2_r;
  logic [DATA_W-1:0]        mag_nxt [3];
  logic [DATA_W-1:0]        mag2_r [3];
  logic                     neg2_r [3];

  side_t                    side_nxt, side3_r;
  logic [SQ_W-1:0]          sq_nxt, sq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op;
      a1_r[0] <= ax;
      a1_r[1] <= ay;
      a1_r[2] <= az;
      b1_r[0] <= bx;
      b1_r[1] <= by;
      b1_r[2] <= bz;
      s1_r    <= sf;
    end
  end

  // operand selection for the six shared multipliers
  always_comb begin
    case (op1_r)
      OP_SCALE: begin
        lhs[0] = a1_r[0]; rhs[0] = s1_r;
        lhs[1] = a1_r[1]; rhs[1] = s1_r;
        lhs[2] = a1_r[2]; rhs[2] = s1_r;
      end
      OP_DOT: begin
        lhs[0] = a1_r[0]; rhs[0] = b1_r[0];
        lhs[1] = a1_r[1]; rhs[1] = b1_r[1];
        lhs[2] = a1_r[2]; rhs[2] = b1_r[2];
      end
      OP_CROSS: begin
        lhs[0] = a1_r[1]; rhs[0] = b1_r[2];
        lhs[1] = a1_r[2]; rhs[1] = b1_r[0];
        lhs[2] = a1_r[0]; rhs[2] = b1_r[1];
      end
      default: begin
        lhs[0] = a1_r[0]; rhs[0] = a1_r[0];
        lhs[1] = a1_r[1]; rhs[1] = a1_r[1];
        lhs[2] = a1_r[2]; rhs[2] = a1_r[2];
      end
    endcase
    lhs[3] = a1_r[2]; rhs[3] = b1_r[1];
    lhs[4] = a1_r[0]; rhs[4] = b1_r[2];
    lhs[5] = a1_r[1]; rhs[5] = b1_r[0];
  end

  always_comb begin
    logic signed [DATA_W:0] ea, eb, w;
    for (int i = 0; i < 3; i++) begin
      ea = {a1_r[i][DATA_W-1], a1_r[i]};
      eb = {b1_r[i][DATA_W-1], b1_r[i]};
      case (op1_r)
        OP_ADD:  w = ea + eb;
        OP_SUB:  w = ea - eb;
        OP_NEG:  w = -ea;
        default: w = '0;
      endcase
      vec_nxt[i] = sat_wide(SUM_W'(w));
      mag_nxt[i] = a1_r[i][DATA_W-1] ? DATA_W'(-a1_r[i]) : a1_r[i];
    end
    eq_nxt = (op1_r == OP_EQUAL) && (a1_r[0] == b1_r[0]) &&
             (a1_r[1] == b1_r[1]) && (a1_r[2] == b1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) p2_r[i] <= PROD_W'(lhs[i]) * PROD_W'(rhs[i]);
      for (int i = 0; i < 3; i++) begin
        vec2_r[i] <= vec_nxt[i];
        mag2_r[i] <= mag_nxt[i];
        neg2_r[i] <= a1_r[i][DATA_W-1];
      end
      eq2_r <= eq_nxt;
      op2_r <= op1_r;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] t [3];
    logic signed [SUM_W-1:0] dot;
    sat_t                    r [3];
    sat_t                    rd;
    logic [SQ_W-1:0]         sqs;

    sq_nxt = SQ_W'(p2_r[0]) + SQ_W'(p2_r[1]) + SQ_W'(p2_r[2]);
    sqs    = sq_nxt >> FRAC_BITS;
    dot    = (SUM_W'(p2_r[0]) + SUM_W'(p2_r[1]) + SUM_W'(p2_r[2])) >>> FRAC_BITS;
    rd     = sat_wide(dot);
    for (int i = 0; i < 3; i++) begin
      if (op2_r == OP_CROSS) t[i] = (SUM_W'(p2_r[i]) - SUM_W'(p2_r[i+3])) >>> FRAC_BITS;
      else                   t[i] = SUM_W'(p2_r[i]) >>> FRAC_BITS;
      r[i] = sat_wide(t[i]);
    end

    side_nxt     = '0;
    side_nxt.op  = op2_r;
    side_nxt.mx  = mag2_r[0];
    side_nxt.my  = mag2_r[1];
    side_nxt.mz  = mag2_r[2];
    side_nxt.nx  = neg2_r[0];
    side_nxt.ny  = neg2_r[1];
    side_nxt.nz  = neg2_r[2];
    case (op2_r) inside
      OP_ADD, OP_SUB, OP_NEG: begin
        side_nxt.vx  = vec2_r[0].val;
        side_nxt.vy  = vec2_r[1].val;
        side_nxt.vz  = vec2_r[2].val;
        side_nxt.ovf = vec2_r[0].ovf | vec2_r[1].ovf | vec2_r[2].ovf;
      end
      OP_SCALE, OP_CROSS: begin
        side_nxt.vx  = r[0].val;
        side_nxt.vy  = r[1].val;
        side_nxt.vz  = r[2].val;
        side_nxt.ovf = r[0].ovf | r[1].ovf | r[2].ovf;
      end
      OP_DOT: begin
        side_nxt.sc  = rd.val;
        side_nxt.ovf = rd.ovf;
      end
      OP_SQLEN: begin
        if (|sqs[SQ_W-1:DATA_W-1]) begin
          side_nxt.sc  = VAL_MAX;
          side_nxt.ovf = 1'b1;
        end else begin
          side_nxt.sc  = sqs[DATA_W-1:0];
        end
      end
      OP_EQUAL: side_nxt.eq = eq2_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side_nxt;
      sq3_r   <= sq_nxt;
    end
  end

  assign out_vld  = vld3_r;
  assign out_side = side3_r;
  assign out_sq   = sq3_r;

endmodule

// ===== hw/rtl/v3au_sqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// v3au_sqrt
// Pipelined floor square root, one root bit per stage, item data alongside.
// ---------------------------------------------------------------------------
module v3au_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  v3au_pkg::side_t               in_side,
  input  logic [v3au_pkg::SQ_W-1:0]     in_rad,
  output logic                          out_vld,
  output v3au_pkg::side_t               out_side,
  output logic [v3au_pkg::ROOT_W-1:0]   out_root
);
  import v3au_pkg::*;

  logic              vld_r  [ROOT_W];
  side_t             side_r [ROOT_W];
  logic [SQ_W-1:0]   rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_p;
    side_t             side_p;
    logic [SQ_W-1:0]   rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W+1:0]  pre, tst;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign side_p = in_side;
      assign rad_p  = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign side_p = side_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    always_comb begin
      pre = {rem_p, rad_p[SQ_W-1:SQ_W-2]};
      tst = {2'b00, root_p, 2'b01};
      if (pre >= tst) begin
        rem_nxt  = REM_W'(pre - tst);
        root_nxt = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = pre[REM_W-1:0];
        root_nxt = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_p;
        rad_r[k]  <= {rad_p[SQ_W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];

endmodule

// ===== hw/rtl/v3au_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// v3au_div
// Pipelined restoring divider for one normalize lane, one quotient bit per
// stage; big flags a quotient beyond the kept bits.
// ---------------------------------------------------------------------------
module v3au_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [v3au_pkg::DVD_W-1:0]    dvd,
  input  logic [v3au_pkg::ROOT_W-1:0]   dvs,
  output logic [v3au_pkg::QUO_W-1:0]    quo,
  output logic                          big
);
  import v3au_pkg::*;

  localparam int CMP_W = ROOT_W + QUO_W;

  logic [DVD_W-1:0]  rem_r [QUO_W];
  logic [ROOT_W-1:0] dvs_r [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];
  logic              big_r [QUO_W];

  genvar k;
  for (k = 0; k < QUO_W; k++) begin : g_stage
    logic [DVD_W-1:0]  rem_p;
    logic [ROOT_W-1:0] dvs_p;
    logic [QUO_W-1:0]  quo_p;
    logic              big_p;
    logic [CMP_W-1:0]  sh;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_p = dvd;
      assign dvs_p = dvs;
      assign quo_p = '0;
      assign big_p = ROOT_W'(dvd[DVD_W-1:QUO_W]) >= dvs;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign dvs_p = dvs_r[k-1];
      assign quo_p = quo_r[k-1];
      assign big_p = big_r[k-1];
    end

    assign sh = CMP_W'(dvs_p) << (QUO_W - 1 - k);
    assign ge = CMP_W'(rem_p) >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DVD_W'(CMP_W'(rem_p) - sh) : rem_p;
        dvs_r[k] <= dvs_p;
        quo_r[k] <= {quo_p[QUO_W-2:0], ge};
        big_r[k] <= big_p;
      end
    end
  end

  assign quo = quo_r[QUO_W-1];
  assign big = big_r[QUO_W-1];

endmodule
